>>> rtl/core/ssds_pkg.sv
// Shared constants and types for the sparse-set domain store.
`default_nettype none

package ssds_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_VARS = 16;
    localparam int DEF_MAX_VALS = 64;

    // Fixed port field widths.
    localparam int ACTION_W   = 3;
    localparam int VAR_IDX_W  = 4;
    localparam int VALUE_W    = 7;
    localparam int SIZE_W     = 7;
    localparam int FIRST_W    = 6;
    localparam int NUM_VALS_W = 7;

    // Value of num_vals after reset.
    localparam logic [NUM_VALS_W-1:0] NUM_VALS_RESET = 7'd64;

    typedef logic [ACTION_W-1:0] action_t;

    // Operation codes.
    localparam action_t ACT_BIND     = 3'd0;
    localparam action_t ACT_REMOVE   = 3'd1;
    localparam action_t ACT_MARK     = 3'd2;
    localparam action_t ACT_CLEAR    = 3'd3;
    localparam action_t ACT_RESTRICT = 3'd4;
    localparam action_t ACT_QUERY    = 3'd5;
    localparam action_t ACT_RESTORE  = 3'd6;

    // One result item.
    typedef struct packed {
        logic               ok;
        logic               bind_event;
        logic [SIZE_W-1:0]  dom_size;
        logic [FIRST_W-1:0] first_value;
        logic               contains;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/core/ssds_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ssds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/sparse_set_domain_store_top.sv
// Sparse-set domain store: top level with control, per-variable counters and the two maps.
// A result passes through ST_POS and ST_SWP into the output register, waiting in ST_HOLD
// while that register is full. A new item is taken only in ST_IDLE, once the last is done;
// the two swap halves use each memory's single write port, in ST_POS and then in ST_SWP.
// Reset (and every num_vals write) starts a pass that rewrites both maps to identity, one
// entry per cycle, MAX_VARS*MAX_VALS pairs (1024 at defaults); no input is taken meanwhile.
`default_nettype none

module sparse_set_domain_store_top #(
    parameter int MAX_VARS = ssds_pkg::DEF_MAX_VARS,
    parameter int MAX_VALS = ssds_pkg::DEF_MAX_VALS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    // Configuration write port for num_vals.
    input  wire logic                             cfg_we,
    input  wire logic [ssds_pkg::NUM_VALS_W-1:0]  cfg_wdata,

    // Input channel.
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [ssds_pkg::ACTION_W-1:0]    action,
    input  wire logic [ssds_pkg::VAR_IDX_W-1:0]   var_index,
    input  wire logic [ssds_pkg::VALUE_W-1:0]     value,
    input  wire logic [ssds_pkg::SIZE_W-1:0]      new_size,

    // Result channel.
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  ok,
    output logic                                  bind_event,
    output logic      [ssds_pkg::SIZE_W-1:0]      dom_size,
    output logic      [ssds_pkg::FIRST_W-1:0]     first_value,
    output logic                                  contains
);

    // Width of a position or value inside one domain.
    localparam int POS_W  = $clog2(MAX_VALS);
    // Width of a size, which may equal MAX_VALS.
    localparam int SZ_W   = $clog2(MAX_VALS + 1);
    // Width of a variable number in the memory address.
    localparam int VAR_W  = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
    localparam int ADDR_W = VAR_W + POS_W;
    localparam int DEPTH  = (1 << VAR_W) * (1 << POS_W);
    // Common width for comparing sizes against the 7-bit port fields.
    localparam int CMP_W  = (SZ_W > ssds_pkg::VALUE_W) ? SZ_W : ssds_pkg::VALUE_W;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_POS  = 2'd1;
    localparam logic [1:0] ST_SWP  = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    // Saturate num_vals to the range 1..MAX_VALS.
    function automatic logic [SZ_W-1:0] eff_of(input logic [ssds_pkg::NUM_VALS_W-1:0] nv);
        logic [SZ_W-1:0] r;
        if (nv == '0)
        begin
            r = SZ_W'(1);
        end
        else if (CMP_W'(nv) > CMP_W'(MAX_VALS))
        begin
            r = SZ_W'(MAX_VALS);
        end
        else
        begin
            r = SZ_W'(nv);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Control and per-variable state
    // ------------------------------------------------------------------
    logic [1:0]                        state_reg;
    logic [ssds_pkg::NUM_VALS_W-1:0]   num_vals_reg;
    logic [SZ_W-1:0]                   n_eff;

    // The initialization pass walks every (variable, position) pair once.
    logic                              clr_active_reg;
    logic [VAR_W-1:0]                  clr_var_reg;
    logic [POS_W-1:0]                  clr_pos_reg;

    // Live size, mark count and a shadow copy of position zero for each variable.
    // The shadow lets the result report first_value without a second array read.
    logic [SZ_W-1:0]                   live_reg  [MAX_VARS];
    logic [SZ_W-1:0]                   mark_reg  [MAX_VARS];
    logic [POS_W-1:0]                  first_reg [MAX_VARS];

    // The item in flight.
    ssds_pkg::action_t                 act_reg;
    logic [ssds_pkg::VAR_IDX_W-1:0]    x_reg;
    logic [ssds_pkg::VALUE_W-1:0]      v_reg;
    logic [ssds_pkg::SIZE_W-1:0]       ns_reg;
    logic                              x_ok_reg;

    // Decisions taken after the position lookup, used for the second swap half.
    logic                              swap_reg;
    logic [POS_W-1:0]                  pos_reg;
    logic                              first_vb_reg;
    logic [POS_W-1:0]                  first_part_reg;
    ssds_pkg::res_t                    res_reg;

    // Output register and the overflow slot for a result that finds it occupied.
    logic                              out_valid_reg;
    ssds_pkg::res_t                    out_res_reg;
    ssds_pkg::res_t                    hold_res_reg;

    logic                              in_xfer;
    logic                              out_free;
    logic                              load_out;
    logic [VAR_W-1:0]                  xi;

    assign n_eff    = eff_of(num_vals_reg);
    assign in_ready = (state_reg == ST_IDLE) && !clr_active_reg;
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign load_out = ((state_reg == ST_SWP) || (state_reg == ST_HOLD)) && out_free;
    assign xi       = VAR_W'(x_reg);

    // ------------------------------------------------------------------
    // Memories: value at each position, and position of each value
    // ------------------------------------------------------------------
    logic              vap_we;
    logic [ADDR_W-1:0] vap_waddr;
    logic [POS_W-1:0]  vap_wdata;
    logic [ADDR_W-1:0] vap_raddr;
    logic [POS_W-1:0]  vap_rdata;

    logic              pov_we;
    logic [ADDR_W-1:0] pov_waddr;
    logic [POS_W-1:0]  pov_wdata;
    logic [ADDR_W-1:0] pov_raddr;
    logic [POS_W-1:0]  pov_rdata;

    ssds_ram #(
        .WIDTH (POS_W),
        .DEPTH (DEPTH)
    ) u_vap_ram (
        .clk   (clk),
        .we    (vap_we),
        .waddr (vap_waddr),
        .wdata (vap_wdata),
        .raddr (vap_raddr),
        .rdata (vap_rdata)
    );

    ssds_ram #(
        .WIDTH (POS_W),
        .DEPTH (DEPTH)
    ) u_pov_ram (
        .clk   (clk),
        .we    (pov_we),
        .waddr (pov_waddr),
        .wdata (pov_wdata),
        .raddr (pov_raddr),
        .rdata (pov_rdata)
    );

    // ------------------------------------------------------------------
    // Decision logic, evaluated in ST_POS once the operand's position is known
    // ------------------------------------------------------------------
    logic [SZ_W-1:0]  sz_c;
    logic [SZ_W-1:0]  m_c;
    logic             inr_c;
    logic [POS_W-1:0] pos_c;
    logic             present_c;
    logic             ok_c;
    logic             ev_c;
    logic [SZ_W-1:0]  szf_c;
    logic [SZ_W-1:0]  markf_c;
    logic             swap_c;
    logic [POS_W-1:0] tgt_c;
    logic [SZ_W-1:0]  nsc_c;
    logic [POS_W-1:0] vpos_c;

    always_comb
    begin
        sz_c      = x_ok_reg ? live_reg[xi] : '0;
        m_c       = x_ok_reg ? mark_reg[xi] : '0;
        inr_c     = CMP_W'(v_reg) < CMP_W'(n_eff);
        pos_c     = inr_c ? pov_rdata : '0;
        present_c = inr_c && (SZ_W'(pos_c) < sz_c);
        nsc_c     = (CMP_W'(ns_reg) > CMP_W'(n_eff)) ? n_eff : SZ_W'(ns_reg);
        ok_c      = 1'b1;
        ev_c      = 1'b0;
        szf_c     = sz_c;
        markf_c   = m_c;
        swap_c    = 1'b0;
        tgt_c     = pos_c;

        case (act_reg)
            ssds_pkg::ACT_BIND:
            begin
                markf_c = '0;
                if (!present_c)
                begin
                    ok_c = 1'b0;
                end
                else if (sz_c != SZ_W'(1))
                begin
                    // Move the bound value to the front.
                    tgt_c  = '0;
                    swap_c = (pos_c != '0);
                    szf_c  = SZ_W'(1);
                    ev_c   = 1'b1;
                end
            end
            ssds_pkg::ACT_REMOVE:
            begin
                markf_c = '0;
                if (present_c)
                begin
                    if (sz_c <= SZ_W'(1))
                    begin
                        ok_c = 1'b0;
                    end
                    else
                    begin
                        // Swap the removed value to the last live position.
                        szf_c  = sz_c - SZ_W'(1);
                        tgt_c  = POS_W'(szf_c);
                        swap_c = (pos_c != tgt_c);
                        ev_c   = (szf_c == SZ_W'(1));
                    end
                end
            end
            ssds_pkg::ACT_MARK:
            begin
                if (present_c && (SZ_W'(pos_c) >= m_c) && (CMP_W'(m_c) < CMP_W'(MAX_VALS)))
                begin
                    // Swap the value into the marked prefix.
                    tgt_c   = POS_W'(m_c);
                    swap_c  = (pos_c != tgt_c);
                    markf_c = m_c + SZ_W'(1);
                end
            end
            ssds_pkg::ACT_CLEAR:
            begin
                markf_c = '0;
            end
            ssds_pkg::ACT_RESTRICT:
            begin
                markf_c = '0;
                if (m_c != sz_c)
                begin
                    szf_c = m_c;
                    ok_c  = (m_c != '0);
                    ev_c  = (m_c == SZ_W'(1));
                end
            end
            ssds_pkg::ACT_RESTORE:
            begin
                szf_c   = nsc_c;
                markf_c = (m_c > nsc_c) ? nsc_c : m_c;
                ok_c    = (nsc_c != '0);
            end
            default:
            begin
                // Query and the unused code leave the domain as it is.
            end
        endcase

        vpos_c = swap_c ? tgt_c : pos_c;
    end

    // ------------------------------------------------------------------
    // Memory port steering
    // ------------------------------------------------------------------
    always_comb
    begin
        vap_we    = 1'b0;
        vap_waddr = {clr_var_reg, clr_pos_reg};
        vap_wdata = clr_pos_reg;
        pov_we    = 1'b0;
        pov_waddr = {clr_var_reg, clr_pos_reg};
        pov_wdata = clr_pos_reg;

        // The position map is looked up straight from the input ports at the transfer.
        pov_raddr = {VAR_W'(var_index), POS_W'(value)};
        // The value at the swap target is looked up during ST_POS.
        vap_raddr = {xi, tgt_c};

        if (clr_active_reg)
        begin
            // Initialization pass: identity in both maps.
            vap_we = 1'b1;
            pov_we = 1'b1;
        end
        else if ((state_reg == ST_POS) && swap_c && x_ok_reg)
        begin
            // First half of the swap: the operand lands at the target.
            // The target's old value is read in the same cycle, before the write.
            vap_we    = 1'b1;
            vap_waddr = {xi, tgt_c};
            vap_wdata = POS_W'(v_reg);
            pov_we    = 1'b1;
            pov_waddr = {xi, POS_W'(v_reg)};
            pov_wdata = tgt_c;
        end
        else if ((state_reg == ST_SWP) && swap_reg)
        begin
            // Second half: the displaced value takes the operand's old position.
            vap_we    = 1'b1;
            vap_waddr = {xi, pos_reg};
            vap_wdata = vap_rdata;
            pov_we    = 1'b1;
            pov_waddr = {xi, vap_rdata};
            pov_wdata = pos_reg;
        end
    end

    // ------------------------------------------------------------------
    // Result assembly in ST_SWP
    // ------------------------------------------------------------------
    logic [POS_W-1:0] first_fin;
    ssds_pkg::res_t   res_fin;

    always_comb
    begin
        first_fin = first_vb_reg ? vap_rdata : first_part_reg;
        res_fin   = res_reg;
        res_fin.first_value = x_ok_reg ? ssds_pkg::FIRST_W'(first_fin) : '0;
    end

    // ------------------------------------------------------------------
    // Sequencer, counters and per-variable state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            num_vals_reg   <= ssds_pkg::NUM_VALS_RESET;
            clr_active_reg <= 1'b1;
            clr_var_reg    <= '0;
            clr_pos_reg    <= '0;
            out_valid_reg  <= 1'b0;
            swap_reg       <= 1'b0;
            for (int i = 0; i < MAX_VARS; i++)
            begin
                live_reg[i]  <= eff_of(ssds_pkg::NUM_VALS_RESET);
                mark_reg[i]  <= '0;
                first_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                // A new num_vals reinitializes every domain and restarts the pass.
                num_vals_reg   <= cfg_wdata;
                clr_active_reg <= 1'b1;
                clr_var_reg    <= '0;
                clr_pos_reg    <= '0;
                for (int i = 0; i < MAX_VARS; i++)
                begin
                    live_reg[i]  <= eff_of(cfg_wdata);
                    mark_reg[i]  <= '0;
                    first_reg[i] <= '0;
                end
            end
            else
            begin
                if (clr_active_reg)
                begin
                    if (clr_pos_reg == POS_W'(MAX_VALS - 1))
                    begin
                        clr_pos_reg <= '0;
                        if (clr_var_reg == VAR_W'(MAX_VARS - 1))
                        begin
                            clr_active_reg <= 1'b0;
                        end
                        else
                        begin
                            clr_var_reg <= clr_var_reg + VAR_W'(1);
                        end
                    end
                    else
                    begin
                        clr_pos_reg <= clr_pos_reg + POS_W'(1);
                    end
                end

                if ((state_reg == ST_POS) && x_ok_reg)
                begin
                    live_reg[xi] <= szf_c;
                    mark_reg[xi] <= markf_c;
                end

                if ((state_reg == ST_SWP) && x_ok_reg)
                begin
                    first_reg[xi] <= first_fin;
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        state_reg <= ST_POS;
                    end
                end
                ST_POS:
                begin
                    swap_reg  <= swap_c && x_ok_reg;
                    state_reg <= ST_SWP;
                end
                ST_SWP:
                begin
                    swap_reg  <= 1'b0;
                    state_reg <= out_free ? ST_IDLE : ST_HOLD;
                end
                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: item fields, decisions and result data.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            act_reg  <= action;
            x_reg    <= var_index;
            v_reg    <= value;
            ns_reg   <= new_size;
            x_ok_reg <= (32'(var_index) < MAX_VARS);
        end

        if (state_reg == ST_POS)
        begin
            pos_reg        <= pos_c;
            first_vb_reg   <= swap_c && (tgt_c != '0) && (pos_c == '0);
            first_part_reg <= (swap_c && (tgt_c == '0)) ? POS_W'(v_reg)
                            : (x_ok_reg ? first_reg[xi] : '0);
            res_reg.ok          <= ok_c && x_ok_reg;
            res_reg.bind_event  <= ev_c && x_ok_reg;
            res_reg.dom_size    <= x_ok_reg ? ssds_pkg::SIZE_W'(szf_c) : '0;
            res_reg.first_value <= '0;
            res_reg.contains    <= x_ok_reg && inr_c && (SZ_W'(vpos_c) < szf_c);
        end

        if ((state_reg == ST_SWP) && !out_free)
        begin
            hold_res_reg <= res_fin;
        end

        if (load_out)
        begin
            out_res_reg <= (state_reg == ST_SWP) ? res_fin : hold_res_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign ok          = out_res_reg.ok;
    assign bind_event  = out_res_reg.bind_event;
    assign dom_size    = out_res_reg.dom_size;
    assign first_value = out_res_reg.first_value;
    assign contains    = out_res_reg.contains;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The second half of a swap moves a value other than the operand; a stale
    // read of the target would show up as the operand coming back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWP) && swap_reg |-> (vap_rdata != POS_W'(v_reg)))
        else $error("swap read returned the operand itself");

    // A result only waits in the overflow slot while the output register is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD) |-> out_valid_reg)
        else $error("result held while the output register was free");

    // The marked prefix never reaches past the live domain.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWP) && x_ok_reg |-> (mark_reg[xi] <= live_reg[xi]))
        else $error("mark count exceeds domain size");

    // A domain never grows beyond the effective value count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWP) && x_ok_reg |-> (live_reg[xi] <= n_eff))
        else $error("domain size exceeds num_vals");

endmodule

`default_nettype wire
